[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BDE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/bde_pkg.sv]
package bde_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int DATA_W   = 32;
    localparam int ST_W     = 2;
    localparam int CNTF_W   = 7;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_COUNT      = 3'd4;
    localparam logic [OP_W-1:0] OP_ERASE      = 3'd5;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic signed [DATA_W-1:0] NO_VALUE = -32'sd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_SCAN,
        S_RD_F,
        S_RD_B,
        S_RD_BW,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] popped_value;
        logic [CNTF_W-1:0]        match_count;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic [CNTF_W-1:0]        occupancy;
    } t_result;

    // ring index add, both operands below CAPACITY
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IDX_W+1)'(CAPACITY)) begin
            s = s - (IDX_W+1)'(CAPACITY);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

[rtl/core/bde_if.sv]
interface bde_req_if import bde_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] operand_value;

    modport source (output valid, output operation, output operand_value, input ready);
    modport sink   (input valid, input operation, input operand_value, output ready);
endinterface

interface bde_rsp_if import bde_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] popped_value;
    logic [CNTF_W-1:0]        match_count;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [CNTF_W-1:0]        occupancy;

    modport source (output valid, output status, output popped_value, output match_count,
                    output front_value, output back_value, output occupancy, input ready);
    modport sink   (input valid, input status, input popped_value, input match_count,
                    input front_value, input back_value, input occupancy, output ready);
endinterface

[rtl/core/bde_ram.sv]
// Simple dual-port RAM: one write, one registered read.
module bde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/bounded_deque_with_erase.sv]
// Bounded double-ended queue of signed 32-bit words, CAPACITY entries deep.
// Request channel i_req: operation (push front/back, pop front/back, count,
// erase) and operand_value. Response channel o_rsp: one response per request
// with status, popped value, match count, front/back values and occupancy.
// Entries live in a ring inside a single-port-read RAM; a small sequencer
// drives that RAM and one shared equality comparator.
// Each request passes EXEC, then POP for a pop of a non-empty queue or SCAN for
// count / erase (one entry per cycle), then RD_F and, unless the queue is empty,
// RD_B and RD_BW to refresh the front and back values, then DONE.
// One request is in flight at a time; i_req.ready rises in the same cycle as
// o_rsp.valid for the previous response. Every entry, plus the front and back
// refresh, costs one read each on the RAM read port.
// Reset (synchronous, active low) empties the queue and drops any pending
// response; RAM contents are never cleared since only data read from written slots is used.
// A stalled receiver holds the response in the output register; the block
// finishes the next request and then waits for that register to drain.
`include "assert_macros.svh"

module bounded_deque_with_erase import bde_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bde_req_if.sink    i_req,
    bde_rsp_if.source  o_rsp
);
    // sequencer and ring pointers
    t_state                   r_state, n_state;
    logic [IDX_W-1:0]         r_head, n_head;
    logic [CNT_W-1:0]         r_count, n_count;
    // latched request
    logic [OP_W-1:0]          r_op, n_op;
    logic signed [DATA_W-1:0] r_val, n_val;
    // scan: read offset, write offset, read-in-flight flag
    logic [CNT_W-1:0]         r_idx, n_idx;
    logic [CNT_W-1:0]         r_wr, n_wr;
    logic                     r_pv, n_pv;
    // response fields under construction
    logic [CNT_W-1:0]         r_match, n_match;
    logic [ST_W-1:0]          r_status, n_status;
    logic signed [DATA_W-1:0] r_popped, n_popped;
    logic signed [DATA_W-1:0] r_front, n_front;
    logic signed [DATA_W-1:0] r_back, n_back;
    // output register
    t_result                  r_out, n_out;
    logic                     r_out_valid, n_out_valid;

    // RAM port
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [IDX_W-1:0]         ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    logic                     req_acc;
    logic                     full, empty, scan_done, hit, out_free;
    logic [CNT_W-1:0]         cnt_m1;
    logic [IDX_W-1:0]         head_dec, head_inc, tail_slot, push_slot, scan_rd, scan_wr;

    bde_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;

    assign full      = (r_count == CNT_W'(CAPACITY));
    assign empty     = (r_count == '0);
    assign cnt_m1    = r_count - 1'b1;
    assign head_dec  = (r_head == '0) ? IDX_W'(CAPACITY - 1) : r_head - 1'b1;
    assign head_inc  = (r_head == IDX_W'(CAPACITY - 1)) ? '0 : r_head + 1'b1;
    assign tail_slot = wrap_add(r_head, cnt_m1[IDX_W-1:0]);
    assign push_slot = wrap_add(r_head, r_count[IDX_W-1:0]);
    assign scan_rd   = wrap_add(r_head, r_idx[IDX_W-1:0]);
    assign scan_wr   = wrap_add(r_head, r_wr[IDX_W-1:0]);
    assign scan_done = (r_idx == r_count) && !r_pv;
    // the one shared comparator
    assign hit       = ($signed(ram_rdata) == r_val);
    assign out_free  = !r_out_valid || o_rsp.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) n_state = S_EXEC;
            end
            S_EXEC: begin
                case (r_op) inside
                    OP_POP_FRONT, OP_POP_BACK: n_state = empty ? S_RD_F : S_POP;
                    OP_COUNT, OP_ERASE:        n_state = S_SCAN;
                    default:                   n_state = S_RD_F;
                endcase
            end
            S_POP:   n_state = S_RD_F;
            S_SCAN: begin
                if (scan_done) n_state = S_RD_F;
            end
            S_RD_F:  n_state = empty ? S_DONE : S_RD_B;
            S_RD_B:  n_state = S_RD_BW;
            S_RD_BW: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_op        = r_op;
        n_val       = r_val;
        n_idx       = r_idx;
        n_wr        = r_wr;
        n_pv        = r_pv;
        n_match     = r_match;
        n_status    = r_status;
        n_popped    = r_popped;
        n_front     = r_front;
        n_back      = r_back;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        ram_we      = 1'b0;
        ram_waddr   = push_slot;
        ram_wdata   = r_val;
        ram_raddr   = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_op     = i_req.operation;
                    n_val    = i_req.operand_value;
                    n_status = ST_OK;
                    n_popped = NO_VALUE;
                    n_match  = '0;
                    n_idx    = '0;
                    n_wr     = '0;
                    n_pv     = 1'b0;
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_PUSH_FRONT: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = head_dec;
                            n_head    = head_dec;
                            n_count   = r_count + 1'b1;
                        end
                    end
                    OP_PUSH_BACK: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = push_slot;
                            n_count   = r_count + 1'b1;
                        end
                    end
                    OP_POP_FRONT: begin
                        if (empty) n_status = ST_EMPTY;
                        ram_raddr = r_head;
                    end
                    OP_POP_BACK: begin
                        if (empty) n_status = ST_EMPTY;
                        ram_raddr = tail_slot;
                    end
                    default: ;
                endcase
            end
            S_POP: begin
                n_popped = ram_rdata;
                n_count  = cnt_m1;
                if (r_op == OP_POP_FRONT) n_head = head_inc;
            end
            S_SCAN: begin
                // read runs one entry ahead of compare; writes never pass reads
                ram_raddr = scan_rd;
                if (r_idx != r_count) begin
                    n_idx = r_idx + 1'b1;
                    n_pv  = 1'b1;
                end else begin
                    n_pv  = 1'b0;
                end
                if (r_pv) begin
                    if (hit) begin
                        n_match = r_match + 1'b1;
                    end else if (r_op == OP_ERASE) begin
                        ram_we    = 1'b1;
                        ram_waddr = scan_wr;
                        ram_wdata = ram_rdata;
                        n_wr      = r_wr + 1'b1;
                    end
                end
                if (scan_done && (r_op == OP_ERASE)) n_count = r_wr;
            end
            S_RD_F: begin
                ram_raddr = r_head;
                if (empty) begin
                    n_front = NO_VALUE;
                    n_back  = NO_VALUE;
                end
            end
            S_RD_B: begin
                n_front   = ram_rdata;
                ram_raddr = tail_slot;
            end
            S_RD_BW: begin
                n_back = ram_rdata;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.status       = r_status;
                    n_out.popped_value = r_popped;
                    n_out.match_count  = CNTF_W'(r_match);
                    n_out.front_value  = r_front;
                    n_out.back_value   = r_back;
                    n_out.occupancy    = CNTF_W'(r_count);
                    n_out_valid        = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pv        <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_wr     <= n_wr;
        r_match  <= n_match;
        r_status <= n_status;
        r_popped <= n_popped;
        r_front  <= n_front;
        r_back   <= n_back;
        r_out    <= n_out;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.popped_value = r_out.popped_value;
    assign o_rsp.match_count  = r_out.match_count;
    assign o_rsp.front_value  = r_out.front_value;
    assign o_rsp.back_value   = r_out.back_value;
    assign o_rsp.occupancy    = r_out.occupancy;

    `BDE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY), "occupancy above capacity")
    `BDE_ASSERT_IMP(a_head_bound, i_clk, i_rst_n, 1'b1, r_head <= IDX_W'(CAPACITY - 1), "head index out of ring")
    `BDE_ASSERT_IMP(a_scan_order, i_clk, i_rst_n, r_state == S_SCAN, r_wr <= r_idx, "erase write passed read")
    `BDE_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, req_acc, !i_req.ready, "second request taken while busy")

endmodule

[bench/deque_checker.sv]
module deque_checker import bde_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bde_req_if   i_req,
    bde_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_outstanding
);

    // shadow copy of the ring
    logic signed [DATA_W-1:0] ring [CAPACITY];
    int      front_slot = 0;
    int      held       = 0;
    int      fails      = 0;
    t_result due_replies [$];

    function automatic int slot_at(input int offset);
        return (front_slot + offset) % CAPACITY;
    endfunction

    // applies one request to the shadow ring, returns the response it should get
    function automatic t_result deque_apply(input logic [OP_W-1:0] op,
                                            input logic signed [DATA_W-1:0] v);
        t_result                  r;
        int                       kept;
        int                       hits;
        logic signed [DATA_W-1:0] e;
        r              = '0;
        r.status       = ST_OK;
        r.popped_value = NO_VALUE;
        hits           = 0;
        case (op)
            OP_PUSH_FRONT: begin
                if (held >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    front_slot       = (front_slot + CAPACITY - 1) % CAPACITY;
                    ring[front_slot] = v;
                    held++;
                end
            end
            OP_PUSH_BACK: begin
                if (held >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    ring[slot_at(held)] = v;
                    held++;
                end
            end
            OP_POP_FRONT: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped_value = ring[front_slot];
                    front_slot     = (front_slot + 1) % CAPACITY;
                    held--;
                end
            end
            OP_POP_BACK: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped_value = ring[slot_at(held - 1)];
                    held--;
                end
            end
            OP_COUNT: begin
                for (int i = 0; i < held; i++) begin
                    if (ring[slot_at(i)] == v) hits++;
                end
            end
            OP_ERASE: begin
                // survivors packed toward the front, order kept
                kept = 0;
                for (int i = 0; i < held; i++) begin
                    e = ring[slot_at(i)];
                    if (e == v) begin
                        hits++;
                    end else begin
                        ring[slot_at(kept)] = e;
                        kept++;
                    end
                end
                held = kept;
            end
            default: ;
        endcase
        r.match_count = hits[CNTF_W-1:0];
        r.occupancy   = held[CNTF_W-1:0];
        if (held == 0) begin
            r.front_value = NO_VALUE;
            r.back_value  = NO_VALUE;
        end else begin
            r.front_value = ring[front_slot];
            r.back_value  = ring[slot_at(held - 1)];
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            front_slot = 0;
            held       = 0;
            due_replies.delete();
        end else begin
            // response first: it always belongs to an older request
            if (i_rsp.valid && i_rsp.ready) begin
                if (due_replies.size() == 0) begin
                    $error("response with no request outstanding");
                    fails++;
                end else begin
                    want = due_replies[0];
                    due_replies.delete(0);
                    check_field("status",       want.status,       i_rsp.status);
                    check_field("popped_value", want.popped_value, i_rsp.popped_value);
                    check_field("match_count",  want.match_count,  i_rsp.match_count);
                    check_field("front_value",  want.front_value,  i_rsp.front_value);
                    check_field("back_value",   want.back_value,   i_rsp.back_value);
                    check_field("occupancy",    want.occupancy,    i_rsp.occupancy);
                end
            end
            if (i_req.valid && i_req.ready) begin
                due_replies.push_back(deque_apply(i_req.operation, i_req.operand_value));
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= due_replies.size();
    end

endmodule

[bench/testbench.sv]
module testbench;
    import bde_pkg::*;

    // codes outside the defined set; the block must pass them through untouched
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam int RANDOM_ITEMS = 700;
    // long receiver hold-off: block parks one response, takes one more request,
    // then must stall its request side
    localparam int LONG_HOLD    = 400;
    // cycles with no handshake at all before we call it hung; worst honest case
    // is the hold-off plus a full-ring scan
    localparam int QUIET_LIMIT  = 4000;
    // tail after the last response: a little over the longest scan latency
    localparam int DRAIN_CYCLES = CAPACITY + 24;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} t_phase;
    typedef enum {VAL_SINGLE, VAL_FEW, VAL_ANY, VAL_EDGES} t_value_mix;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bde_req_if req_ch ();
    bde_rsp_if rsp_ch ();

    int  fail_count;
    int  outstanding;
    int  quiet_cycles = 0;
    bit  hold_off_go  = 1'b0;
    int  burst_left   = 0;
    logic signed [DATA_W-1:0] val_pool [4];

    always #5 i_clk = ~i_clk;

    bounded_deque_with_erase i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    deque_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // ------------------------------------------------------------------
    // Request side. Bursts of random length; between bursts a gap that is
    // sometimes zero, sometimes short and sometimes longer than a full scan,
    // so the next request lands on every stage of the block's sequencer.
    // Valid is only dropped when a gap follows, never lowered and raised
    // within the same step.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic signed [DATA_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(CAPACITY / 2, CAPACITY + 20);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= op;
        req_ch.operand_value <= v;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
    endtask

    // op mix per phase; about 2% are spare codes (ignored by the block)
    function automatic logic [OP_W-1:0] pick_op(input t_phase ph);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return ($urandom_range(0, 1) != 0) ? OP_SPARE6 : OP_SPARE7;
        case (ph)
            PH_FILL: begin
                if (r < 92) return ($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                return OP_COUNT;
            end
            PH_DRAIN: begin
                if (r < 87) return ($urandom_range(0, 1) != 0) ? OP_POP_BACK : OP_POP_FRONT;
                if (r < 95) return OP_ERASE;
                return OP_COUNT;
            end
            default: begin
                if (r < 42) return ($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                if (r < 77) return ($urandom_range(0, 1) != 0) ? OP_POP_BACK : OP_POP_FRONT;
                if (r < 90) return OP_COUNT;
                return OP_ERASE;
            end
        endcase
    endfunction

    // small pools make count/erase actually hit; a single value lets the ring
    // fill with 64 equal words (count of 64, erase of everything)
    function automatic logic signed [DATA_W-1:0] pick_value(input t_value_mix mix);
        case (mix)
            VAL_SINGLE: return val_pool[0];
            VAL_FEW:    return val_pool[$urandom_range(0, 3)];
            VAL_EDGES: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7FFF_FFFF;
                    2:       return NO_VALUE;
                    default: return 32'sh0000_0000;
                endcase
            end
            default:    return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        int                sent;
        int                phase_len;
        bit                first_phase;
        t_phase            ph;
        t_value_mix        mix;
        logic [OP_W-1:0]   op;

        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.operation     <= OP_PUSH_FRONT;
        req_ch.operand_value <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: empty-store cases, spare codes, field extremes ---
        send_request(OP_POP_FRONT,  32'sd0);             // pop front on empty
        send_request(OP_POP_BACK,   32'sd0);             // pop back on empty
        send_request(OP_COUNT,      32'sd5);             // count on empty
        send_request(OP_ERASE,      32'sd5);             // erase on empty
        send_request(OP_SPARE6,     32'sh7FFF_FFFF);     // ignored
        send_request(OP_SPARE7,     32'sh8000_0000);     // ignored
        send_request(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_request(OP_PUSH_BACK,  32'sh8000_0000);
        send_request(OP_PUSH_FRONT, NO_VALUE);           // stored -1, looks like "empty"
        send_request(OP_PUSH_BACK,  32'sd0);
        send_request(OP_PUSH_BACK,  NO_VALUE);
        send_request(OP_SPARE7,     NO_VALUE);           // ignored with data held
        send_request(OP_COUNT,      NO_VALUE);           // two hits
        send_request(OP_COUNT,      32'sh7FFF_FFFF);
        send_request(OP_COUNT,      32'sd123);           // no hit, store not empty
        send_request(OP_ERASE,      NO_VALUE);           // both ends removed, order kept
        send_request(OP_PUSH_FRONT, 32'sh5555_5555);
        send_request(OP_PUSH_BACK,  32'shAAAA_AAAA);
        send_request(OP_POP_BACK,   32'sd0);
        send_request(OP_POP_FRONT,  32'sd0);
        send_request(OP_ERASE,      32'sh8000_0000);     // erase in the middle
        send_request(OP_POP_BACK,   32'sd0);
        send_request(OP_POP_FRONT,  32'sd0);             // drains to empty
        send_request(OP_POP_FRONT,  32'sd0);             // empty again

        // receiver's long stall starts during the first fill phase
        hold_off_go <= 1'b1;

        // --- random phases ---
        sent        = 0;
        first_phase = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            if (first_phase) begin
                // straight fill well past capacity: full-store rejects
                ph          = PH_FILL;
                mix         = VAL_ANY;
                phase_len   = 90;
                first_phase = 1'b0;
            end else begin
                ph        = t_phase'($urandom_range(0, 2));
                mix       = t_value_mix'($urandom_range(0, 3));
                phase_len = $urandom_range(20, 120);
            end
            foreach (val_pool[k]) val_pool[k] = $urandom;
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                op = pick_op(ph);
                send_request(op, pick_value(mix));
                if (op <= OP_ERASE) sent++;
            end
        end
        req_ch.valid <= 1'b0;

        // one edge so the checker's count includes the last request
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("** bounded_deque_with_erase: PASSED **");
        end else begin
            $display("** bounded_deque_with_erase: FAILED **");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Response side. Ready duty cycle changes every so often (100% gives
    // stall-free stretches); once, a long hold-off with ready low.
    // ------------------------------------------------------------------
    initial begin : receiver
        int  duty;
        int  left;
        bit  held_off;
        duty     = 100;
        left     = 0;
        held_off = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_go && !held_off) begin
                held_off = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (left == 0) begin
                case ($urandom_range(0, 3))
                    0:       duty = 100;
                    1:       duty = 85;
                    2:       duty = 50;
                    default: duty = 20;
                endcase
                left = $urandom_range(20, 150);
            end
            left--;
            rsp_ch.ready <= ($urandom_range(1, 100) <= duty);
        end
    end

    // watchdog: any handshake on either channel counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** bounded_deque_with_erase: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
